FILE: hdl/miba_pkg.sv
package miba_pkg;

   localparam int SAMPLE_BITS  = 16;
   localparam int MAX_WIDTH    = 4096;
   localparam int COL_BITS     = $clog2(MAX_WIDTH);
   localparam int HEIGHT_LIMIT = 4096;
   localparam int ROW_BITS     = $clog2(HEIGHT_LIMIT);
   localparam int CFG_BITS     = 13;
   localparam int FACT_BITS    = 5;
   localparam int MAX_BIN      = 16;
   localparam int BIN_BITS     = $clog2(MAX_BIN);
   // A bin holds up to MAX_BIN squared pixels.
   localparam int CNT_BITS     = 2 * BIN_BITS + 1;
   localparam int SUM_BITS     = SAMPLE_BITS + 2 * BIN_BITS;
   localparam int DIV_STEPS    = SUM_BITS;
   localparam int STEP_BITS    = $clog2(DIV_STEPS);

   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_BIN_X        = 2'd2;
   localparam logic [1:0] REG_BIN_Y        = 2'd3;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          sample_valid;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] bin_mean;
      logic                          bin_valid;
      logic                          last_bin;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MERGE,
      ST_DIVIDE,
      ST_FINISH
   } miba_state_type;

   typedef struct packed {
      logic accept;
      logic merge;
      logic div_step;
      logic load_out;
   } miba_cmd_type;

   typedef struct packed {
      logic unit;
      logic end_x;
      logic end_y_held;
      logic div_last;
      logic out_free;
   } miba_sts_type;

endpackage

FILE: hdl/miba_ctrl.sv
module miba_ctrl
   import miba_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  miba_sts_type sts,
   output miba_cmd_type cmd
);

   miba_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.unit) begin
                  state_in = ST_FINISH;
               end else if (sts.end_x) begin
                  state_in = ST_MERGE;
               end
            end
         end
         ST_MERGE: begin
            cmd.merge = 1'b1;
            state_in  = sts.end_y_held ? ST_DIVIDE : ST_IDLE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/miba_dp.sv
module miba_dp
   import miba_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  req_payload_type      req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_payload_type      rsp_data,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [CFG_BITS-1:0]  csr_wdata,
   input  miba_cmd_type         cmd,
   output miba_sts_type         sts
);

   // Configuration registers.
   logic [CFG_BITS-1:0]  img_w_ff, img_h_ff;
   logic [FACT_BITS-1:0] bin_x_ff, bin_y_ff;

   // Derived geometry: sizes held as "size minus one", plus the 1x1 bin flag.
   logic [COL_BITS-1:0]  w_m1;
   logic [ROW_BITS-1:0]  h_m1;
   logic [BIN_BITS-1:0]  fx_m1, fy_m1, bx_m1, by_m1;
   logic                 unit;

   // Position counters and the running row sum of the current bin.
   logic [COL_BITS-1:0]  col_ff, col_in, bcol_ff, bcol_in;
   logic [ROW_BITS-1:0]  row_ff, row_in;
   logic [BIN_BITS-1:0]  cib_ff, cib_in, rib_ff, rib_in;
   logic [SUM_BITS-1:0]  run_sum_ff, run_sum_in;
   logic [CNT_BITS-1:0]  run_cnt_ff, run_cnt_in;
   logic                 last_x, last_y, end_x, end_y;
   logic [SUM_BITS-1:0]  add_sum;
   logic [CNT_BITS-1:0]  add_cnt;

   // Values carried from the accepted item to the later steps.
   logic [SUM_BITS-1:0]    pend_sum_ff;
   logic [CNT_BITS-1:0]    pend_cnt_ff;
   logic [COL_BITS-1:0]    idx_ff;
   logic                   row0_ff, end_y_ff, last_ff, unit_ff;
   req_payload_type        item_ff;

   // Line store: count in the upper bits, sum in the lower bits.
   logic [CNT_BITS+SUM_BITS-1:0] line_mem [MAX_WIDTH];
   logic [CNT_BITS+SUM_BITS-1:0] rd_ff;
   logic [SUM_BITS-1:0]          merged_sum;
   logic [CNT_BITS-1:0]          merged_cnt;

   // Restoring divider.
   logic [SUM_BITS-1:0]  quo_ff;
   logic [CNT_BITS-1:0]  rem_ff, div_cnt_ff;
   logic                 neg_ff;
   logic [STEP_BITS-1:0] step_ff;
   logic [CNT_BITS:0]    shifted, diff;
   logic                 ge;
   logic [SUM_BITS-1:0]  mean_full;

   logic                 rsp_valid_ff;
   rsp_payload_type      rsp_data_ff;
   logic                 out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff <= CFG_BITS'(MAX_WIDTH);
         img_h_ff <= CFG_BITS'(HEIGHT_LIMIT);
         bin_x_ff <= FACT_BITS'(1);
         bin_y_ff <= FACT_BITS'(1);
      end else if (csr_we) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  img_w_ff <= csr_wdata;
            REG_IMAGE_HEIGHT: img_h_ff <= csr_wdata;
            REG_BIN_X:        bin_x_ff <= csr_wdata[FACT_BITS-1:0];
            REG_BIN_Y:        bin_y_ff <= csr_wdata[FACT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // A zero register acts as one, an oversized one saturates, and a bin
   // factor never exceeds the image on its axis.
   always_comb begin
      if (img_w_ff == '0) begin
         w_m1 = '0;
      end else if (img_w_ff > CFG_BITS'(MAX_WIDTH)) begin
         w_m1 = COL_BITS'(MAX_WIDTH - 1);
      end else begin
         w_m1 = COL_BITS'(img_w_ff - CFG_BITS'(1));
      end
      if (img_h_ff == '0) begin
         h_m1 = '0;
      end else if (img_h_ff > CFG_BITS'(HEIGHT_LIMIT)) begin
         h_m1 = ROW_BITS'(HEIGHT_LIMIT - 1);
      end else begin
         h_m1 = ROW_BITS'(img_h_ff - CFG_BITS'(1));
      end
      if (bin_x_ff == '0) begin
         fx_m1 = '0;
      end else if (bin_x_ff > FACT_BITS'(MAX_BIN)) begin
         fx_m1 = BIN_BITS'(MAX_BIN - 1);
      end else begin
         fx_m1 = BIN_BITS'(bin_x_ff - FACT_BITS'(1));
      end
      if (bin_y_ff == '0) begin
         fy_m1 = '0;
      end else if (bin_y_ff > FACT_BITS'(MAX_BIN)) begin
         fy_m1 = BIN_BITS'(MAX_BIN - 1);
      end else begin
         fy_m1 = BIN_BITS'(bin_y_ff - FACT_BITS'(1));
      end
      bx_m1 = (COL_BITS'(fx_m1) > w_m1) ? w_m1[BIN_BITS-1:0] : fx_m1;
      by_m1 = (ROW_BITS'(fy_m1) > h_m1) ? h_m1[BIN_BITS-1:0] : fy_m1;
      unit  = (fx_m1 == '0) && (fy_m1 == '0);
   end

   assign last_x = (col_ff >= w_m1);
   assign last_y = (row_ff >= h_m1);
   assign end_x  = (cib_ff >= bx_m1) || last_x;
   assign end_y  = (rib_ff >= by_m1) || last_y;

   assign add_sum = run_sum_ff + (req_data.sample_valid ?
                    {{(SUM_BITS-SAMPLE_BITS){req_data.sample[SAMPLE_BITS-1]}}, req_data.sample}
                    : SUM_BITS'(0));
   assign add_cnt = run_cnt_ff + CNT_BITS'(req_data.sample_valid);

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      bcol_in    = bcol_ff;
      cib_in     = cib_ff;
      rib_in     = rib_ff;
      run_sum_in = run_sum_ff;
      run_cnt_in = run_cnt_ff;
      if (csr_we) begin
         // Any register write starts a new image.
         col_in     = '0;
         row_in     = '0;
         bcol_in    = '0;
         cib_in     = '0;
         rib_in     = '0;
         run_sum_in = '0;
         run_cnt_in = '0;
      end else if (cmd.accept) begin
         if (!unit) begin
            run_sum_in = add_sum;
            run_cnt_in = add_cnt;
         end
         if (end_x) begin
            cib_in     = '0;
            bcol_in    = bcol_ff + COL_BITS'(1);
            run_sum_in = '0;
            run_cnt_in = '0;
         end else begin
            cib_in = cib_ff + BIN_BITS'(1);
         end
         if (last_x) begin
            col_in  = '0;
            bcol_in = '0;
            if (last_y) begin
               row_in = '0;
               rib_in = '0;
            end else begin
               row_in = row_ff + ROW_BITS'(1);
               rib_in = end_y ? '0 : rib_ff + BIN_BITS'(1);
            end
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         bcol_ff    <= '0;
         cib_ff     <= '0;
         rib_ff     <= '0;
         run_sum_ff <= '0;
         run_cnt_ff <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         bcol_ff    <= bcol_in;
         cib_ff     <= cib_in;
         rib_ff     <= rib_in;
         run_sum_ff <= run_sum_in;
         run_cnt_ff <= run_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_ff     <= req_data;
         pend_sum_ff <= add_sum;
         pend_cnt_ff <= add_cnt;
         idx_ff      <= bcol_ff;
         row0_ff     <= (rib_ff == '0);
         end_y_ff    <= end_y;
         last_ff     <= last_x && last_y;
         unit_ff     <= unit;
      end
   end

   // The entry is written in the first row of a bin before any later row
   // reads it back.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rd_ff <= line_mem[bcol_ff];
      end
      if (cmd.merge) begin
         line_mem[idx_ff] <= {merged_cnt, merged_sum};
      end
   end

   assign merged_sum = row0_ff ? pend_sum_ff : rd_ff[SUM_BITS-1:0] + pend_sum_ff;
   assign merged_cnt = row0_ff ? pend_cnt_ff
                               : rd_ff[CNT_BITS+SUM_BITS-1:SUM_BITS] + pend_cnt_ff;

   assign shifted = {rem_ff, quo_ff[SUM_BITS-1]};
   assign ge      = (shifted >= {1'b0, div_cnt_ff});
   assign diff    = shifted - {1'b0, div_cnt_ff};

   always_ff @(posedge clock) begin
      if (cmd.merge) begin
         quo_ff     <= merged_sum[SUM_BITS-1] ? SUM_BITS'(-merged_sum) : merged_sum;
         neg_ff     <= merged_sum[SUM_BITS-1];
         rem_ff     <= '0;
         div_cnt_ff <= merged_cnt;
         step_ff    <= '0;
      end else if (cmd.div_step) begin
         quo_ff  <= {quo_ff[SUM_BITS-2:0], ge};
         rem_ff  <= ge ? diff[CNT_BITS-1:0] : shifted[CNT_BITS-1:0];
         step_ff <= step_ff + STEP_BITS'(1);
      end
   end

   // Truncation toward zero: divide magnitudes, then restore the sign.
   assign mean_full = neg_ff ? SUM_BITS'(-quo_ff) : quo_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         if (unit_ff) begin
            rsp_data_ff.bin_mean  <= item_ff.sample;
            rsp_data_ff.bin_valid <= item_ff.sample_valid;
         end else if (div_cnt_ff == '0) begin
            rsp_data_ff.bin_mean  <= '0;
            rsp_data_ff.bin_valid <= 1'b0;
         end else begin
            rsp_data_ff.bin_mean  <= mean_full[SAMPLE_BITS-1:0];
            rsp_data_ff.bin_valid <= 1'b1;
         end
         rsp_data_ff.last_bin <= last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign sts.unit       = unit;
   assign sts.end_x      = end_x;
   assign sts.end_y_held = end_y_ff;
   assign sts.div_last   = (step_ff == STEP_BITS'(DIV_STEPS - 1));
   assign sts.out_free   = out_free;

   a_col_in_image: assert property (@(posedge clock) disable iff (reset)
      col_ff <= w_m1)
      else $error("pixel column ran past the image width");

   a_col_in_bin: assert property (@(posedge clock) disable iff (reset)
      cib_ff <= bx_m1)
      else $error("column within bin ran past the bin width");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("loaded result is not presented");

endmodule

FILE: hdl/masked_image_bin_average.sv
// Masked bin average over a raster image: each item is one pixel with a mask
// bit, and a result item leaves when the bottom-right pixel of a bin arrives,
// carrying the truncated mean of the bin's unmasked pixels. Per-bin-column
// partial sums live in a 4096-entry line store. A pixel that does not close a
// bin column is only accepted; one that closes a bin column but not the bin
// adds a store read, then merge and write back; one that closes a bin adds
// the 24-step restoring divider that forms the mean, plus any wait on the
// output register. With 1x1 bins every pixel skips the merge and divide.
// Any configuration write restarts the image at its top-left pixel.
module masked_image_bin_average
   import miba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_payload_type     req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_payload_type     rsp_data,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [CFG_BITS-1:0] csr_wdata
);

   miba_cmd_type cmd;
   miba_sts_type sts;

   miba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   miba_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
